// ===== hdl/rad_pkg.sv =====
// Shared types, codes and constants of the request admission dispatcher.
`default_nettype none
package rad_pkg;

    localparam int HELPERS_DEF     = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    // counts up to 127 helpers or queue entries
    localparam int CNT_W   = 7;
    localparam int HID_W   = 4;
    localparam int NHID    = 16;
    localparam int ID_W    = 16;
    localparam int TIME_W  = 48;
    localparam int SMP_W   = 24;
    localparam int FB_W    = 5;
    localparam int CFG_W   = 5;
    localparam int AVG_W   = 32;
    localparam int NCLP_W  = 18;
    localparam int PROD_W  = 50;

    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 24;

    // shared serial divider
    localparam int DIV_DW = 52;
    localparam int DIV_VW = 34;

    localparam logic [DIV_DW-1:0] NUM_N    = DIV_DW'(64'd5120000000);
    localparam logic [DIV_DW-1:0] N_MAX    = DIV_DW'(200000);
    localparam logic [DIV_DW-1:0] N_MIN    = DIV_DW'(5);
    localparam logic [17:0]       SCALE_MS = 18'd256000;

    typedef enum logic [2:0] {
        OP_REQ    = 3'd0,
        OP_DONE   = 3'd1,
        OP_HRST   = 3'd2,
        OP_UP     = 3'd3,
        OP_DOWN   = 3'd4,
        OP_SAMPLE = 3'd5,
        OP_TICK   = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        DEC_HELPER   = 3'd0,
        DEC_FALLBACK = 3'd1,
        DEC_QUEUED   = 3'd2,
        DEC_OFFLINE  = 3'd3,
        DEC_EXPIRED  = 3'd4,
        DEC_SLOW     = 3'd5,
        DEC_FULL     = 3'd6
    } t_dec;

    typedef enum logic [1:0] {
        DIV_N    = 2'd0,
        DIV_AVG  = 2'd1,
        DIV_WAIT = 2'd2
    } t_div_sel;

    localparam logic CFG_HELPER_MAX  = 1'b0;
    localparam logic CFG_QUEUE_LIMIT = 1'b1;

    typedef struct packed {
        logic     load;
        logic     do_done;
        logic     do_up;
        logic     do_dn;
        logic     cmp_init;
        logic     cmp_step;
        logic     cmp_fin;
        logic     stk_pop;
        logic     take;
        logic     emit;
        t_dec     dec;
        logic     src_new;
        logic     use_h;
        logic     adv;
        logic     fb_dec;
        logic     enq;
        logic     flush;
        logic     avg_init;
        logic     div_start;
        t_div_sel div_sel;
        logic     n_latch;
        logic     prod_latch;
        logic     avg_store;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic rc_zero;
        logic fc_zero;
        logic fb_zero;
        logic wc_zero;
        logic exp_q;
        logic exp_new;
        logic done_ok;
        logic rst_ok;
        logic cmp_end;
        logic slow_need;
        logic slow;
        logic room;
        logic can_emit;
        logic can_flush;
        logic div_busy;
    } t_stat;

endpackage
`default_nettype wire

// ===== hdl/rad_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module rad_div #(
    parameter int DW = rad_pkg::DIV_DW,
    parameter int VW = rad_pkg::DIV_VW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_busy,
    output logic [DW-1:0]      o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_q[DW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? VW'(trial - {1'b0, r_den}) : trial[VW-1:0];
            r_q   <= {r_q[DW-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_q;
endmodule
`default_nettype wire

// ===== hdl/rad_dp.sv =====
// Datapath: state registers, helper stack, wait queue, divider and result staging.
`default_nettype none
module rad_dp #(
    parameter int HELPERS     = rad_pkg::HELPERS_DEF,
    parameter int QUEUE_DEPTH = rad_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [0:0]                      i_cfg_addr,
    input  wire logic [rad_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic [rad_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  wire logic [2:0]                      i_s_tuser,
    input  wire rad_pkg::t_cmd                   i_cmd,
    output rad_pkg::t_stat                       o_stat,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [rad_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    output logic [2:0]                           o_m_tuser,
    output logic                                 o_m_tlast
);
    import rad_pkg::*;

    localparam int HAW = (HELPERS > 1) ? $clog2(HELPERS) : 1;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // latched request
    t_op               r_op;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_dl;
    logic [TIME_W-1:0] r_now;
    logic [HID_W-1:0]  r_hi;
    logic [SMP_W-1:0]  r_sample;
    logic [FB_W-1:0]   r_fb;

    // configuration and state
    logic [CFG_W-1:0]  r_hm, r_ql;
    logic [CNT_W-1:0]  r_rc, r_fc, r_wc, r_ci, r_cj;
    logic [NHID-1:0]   r_mask;
    logic [AVG_W-1:0]  r_avg;
    logic [QAW-1:0]    r_head;
    logic [NCLP_W-1:0] r_n;
    logic [PROD_W-1:0] r_prod;
    logic [HID_W-1:0]  r_helper;

    // memories
    logic [HID_W-1:0]  r_stk [HELPERS];
    logic [HID_W-1:0]  r_srd;
    logic [ID_W-1:0]   r_qids [QUEUE_DEPTH];
    logic [TIME_W-1:0] r_qdls [QUEUE_DEPTH];
    logic [ID_W-1:0]   r_qid;
    logic [TIME_W-1:0] r_qdl;

    // output and pending result
    logic [ID_W-1:0]   r_o_id, r_p_id;
    t_dec              r_o_dec, r_p_dec;
    logic [HID_W-1:0]  r_o_h, r_p_h;
    logic              r_o_last, r_oval, r_pv;

    logic [CNT_W-1:0]  w_eff, q_eff, hi_ext, fcm1;
    logic              done_ok, rst_ok;
    logic [SMP_W-1:0]  t_eff;
    logic [AVG_W-1:0]  ts;
    logic [DIV_DW-1:0] div_dvd, quot;
    logic [DIV_VW-1:0] div_dsr;
    logic              div_busy;
    logic [CNT_W+31:0] wprod;
    logic [CNT_W+17:0] wden;
    logic [PROD_W:0]   avg_num;
    logic [NCLP_W-1:0] n_clp;
    logic [CNT_W:0]    tail_sum, tail_wrap;
    logic [CNT_W:0]    head_inc;
    logic [HAW-1:0]    stk_ra, stk_wa;
    logic              stk_we;
    logic [HID_W-1:0]  stk_wd;
    logic [ID_W-1:0]   e_id;
    logic [HID_W-1:0]  e_h;

    always_comb begin
        if (r_hm == '0) begin
            w_eff = CNT_W'(1);
        end else if (CNT_W'(r_hm) > CNT_W'(HELPERS)) begin
            w_eff = CNT_W'(HELPERS);
        end else begin
            w_eff = CNT_W'(r_hm);
        end
        q_eff = (CNT_W'(r_ql) > CNT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(r_ql);
    end

    assign hi_ext  = CNT_W'(r_hi);
    assign fcm1    = r_fc - 1'b1;
    assign done_ok = (hi_ext < w_eff) && !r_mask[r_hi] && (r_fc < CNT_W'(HELPERS));
    assign rst_ok  = (hi_ext < w_eff) && r_mask[r_hi];

    assign t_eff   = (r_sample == '0) ? SMP_W'(1) : r_sample;
    assign ts      = {t_eff, 8'h00};
    assign wprod   = (CNT_W+32)'(r_wc) * (CNT_W+32)'(r_avg);
    assign wden    = (CNT_W+18)'(w_eff) * (CNT_W+18)'(SCALE_MS);
    assign avg_num = {1'b0, r_prod} + (PROD_W+1)'(ts);

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_N: begin
                div_dvd = NUM_N;
                div_dsr = DIV_VW'({2'b00, r_avg}) + DIV_VW'({2'b00, ts});
            end
            DIV_AVG: begin
                div_dvd = DIV_DW'(avg_num);
                div_dsr = DIV_VW'(r_n);
            end
            DIV_WAIT: begin
                div_dvd = DIV_DW'(wprod);
                div_dsr = DIV_VW'(wden);
            end
            default: begin
                div_dvd = '0;
                div_dsr = DIV_VW'(1);
            end
        endcase
    end

    rad_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_busy     (div_busy),
        .o_quotient (quot)
    );

    always_comb begin
        priority if (quot > N_MAX) begin
            n_clp = NCLP_W'(N_MAX);
        end else if (quot < N_MIN) begin
            n_clp = NCLP_W'(N_MIN);
        end else begin
            n_clp = quot[NCLP_W-1:0];
        end
    end

    assign tail_sum  = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_wc);
    assign tail_wrap = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                       tail_sum - (CNT_W+1)'(QUEUE_DEPTH) : tail_sum;
    assign head_inc  = (CNT_W+1)'(r_head) + 1'b1;

    // stack ports: pop reads the top, compaction reads at the scan index
    assign stk_ra = i_cmd.stk_pop ? fcm1[HAW-1:0] : r_ci[HAW-1:0];
    assign stk_we = i_cmd.do_done ? done_ok : (i_cmd.cmp_step && (r_srd != r_hi));
    assign stk_wa = i_cmd.do_done ? r_fc[HAW-1:0] : r_cj[HAW-1:0];
    assign stk_wd = i_cmd.do_done ? r_hi : r_srd;

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_wa] <= stk_wd;
        end
        r_srd <= r_stk[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq) begin
            r_qids[tail_wrap[QAW-1:0]] <= r_id;
            r_qdls[tail_wrap[QAW-1:0]] <= r_dl;
        end
        r_qid <= r_qids[r_head];
        r_qdl <= r_qdls[r_head];
    end

    assign e_id = i_cmd.src_new ? r_id : r_qid;
    assign e_h  = i_cmd.use_h ? r_helper : '0;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_s_tuser);
            r_id     <= i_s_tdata[15:0];
            r_dl     <= i_s_tdata[63:16];
            r_now    <= i_s_tdata[111:64];
            r_hi     <= i_s_tdata[115:112];
            r_sample <= i_s_tdata[139:116];
            r_fb     <= i_s_tdata[144:140];
        end else if (i_cmd.fb_dec) begin
            r_fb <= r_fb - 1'b1;
        end
        if (i_cmd.cmp_init) begin
            r_ci <= '0;
            r_cj <= '0;
        end else if (i_cmd.cmp_step) begin
            r_ci <= r_ci + 1'b1;
            if (r_srd != r_hi) begin
                r_cj <= r_cj + 1'b1;
            end
        end
        if (i_cmd.take) begin
            r_helper <= r_srd;
        end
        if (i_cmd.n_latch) begin
            r_n <= n_clp;
        end
        if (i_cmd.prod_latch) begin
            r_prod <= PROD_W'(r_avg) * PROD_W'(r_n - 1'b1);
        end
        if (i_cmd.emit) begin
            r_p_id  <= e_id;
            r_p_dec <= i_cmd.dec;
            r_p_h   <= e_h;
            if (r_pv) begin
                r_o_id   <= r_p_id;
                r_o_dec  <= r_p_dec;
                r_o_h    <= r_p_h;
                r_o_last <= 1'b0;
            end
        end else if (i_cmd.flush && r_pv) begin
            r_o_id   <= r_p_id;
            r_o_dec  <= r_p_dec;
            r_o_h    <= r_p_h;
            r_o_last <= 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hm   <= CFG_W'(16);
            r_ql   <= CFG_W'(16);
            r_rc   <= '0;
            r_fc   <= '0;
            r_mask <= '0;
            r_avg  <= '0;
            r_head <= '0;
            r_wc   <= '0;
            r_oval <= 1'b0;
            r_pv   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_addr == CFG_HELPER_MAX) begin
                    r_hm <= i_cfg_data;
                end else begin
                    r_ql <= i_cfg_data;
                end
            end
            if (i_cmd.do_done && done_ok) begin
                r_fc         <= r_fc + 1'b1;
                r_mask[r_hi] <= 1'b1;
            end
            if (i_cmd.cmp_fin) begin
                r_fc         <= r_cj;
                r_mask[r_hi] <= 1'b0;
            end
            if (i_cmd.stk_pop) begin
                r_fc <= fcm1;
            end
            if (i_cmd.take) begin
                r_mask[r_srd] <= 1'b0;
            end
            if (i_cmd.do_up && (r_rc < w_eff)) begin
                r_rc <= r_rc + 1'b1;
            end
            if (i_cmd.do_dn && (r_rc != '0)) begin
                r_rc <= r_rc - 1'b1;
            end
            if (i_cmd.avg_init && (r_avg == '0)) begin
                r_avg <= ts;
            end
            if (i_cmd.avg_store) begin
                r_avg <= quot[AVG_W-1:0];
            end
            if (i_cmd.adv) begin
                r_head <= (head_inc == (CNT_W+1)'(QUEUE_DEPTH)) ? '0 : head_inc[QAW-1:0];
                r_wc   <= r_wc - 1'b1;
            end
            if (i_cmd.enq) begin
                r_wc <= r_wc + 1'b1;
            end
            // output register: drop on take, refill from the pending slot
            if (i_m_tready) begin
                r_oval <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_pv <= 1'b1;
                if (r_pv) begin
                    r_oval <= 1'b1;
                end
            end else if (i_cmd.flush && r_pv) begin
                r_pv   <= 1'b0;
                r_oval <= 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.op        = r_op;
        o_stat.rc_zero   = (r_rc == '0);
        o_stat.fc_zero   = (r_fc == '0);
        o_stat.fb_zero   = (r_fb == '0);
        o_stat.wc_zero   = (r_wc == '0);
        o_stat.exp_q     = (r_now >= r_qdl);
        o_stat.exp_new   = (r_now >= r_dl);
        o_stat.done_ok   = done_ok;
        o_stat.rst_ok    = rst_ok;
        o_stat.cmp_end   = (r_ci == r_fc);
        o_stat.slow_need = (r_wc > w_eff);
        o_stat.slow      = (({1'b0, r_now} + (TIME_W+1)'(quot)) >= {1'b0, r_dl});
        o_stat.room      = (r_wc < q_eff);
        o_stat.can_emit  = !r_pv || !r_oval || i_m_tready;
        o_stat.can_flush = !r_oval || i_m_tready;
        o_stat.div_busy  = div_busy;
    end

    assign o_m_tvalid = r_oval;
    assign o_m_tdata  = {4'b0000, r_o_h, r_o_id};
    assign o_m_tuser  = r_o_dec;
    assign o_m_tlast  = r_o_last;
endmodule
`default_nettype wire

// ===== hdl/rad_ctrl.sv =====
// Controller: sequences drain, dispatch, helper updates and delay averaging.
`default_nettype none
module rad_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire rad_pkg::t_stat i_stat,
    output rad_pkg::t_cmd       o_cmd
);
    import rad_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_CRD, S_CUSE, S_DR, S_DDEC, S_POP, S_TAKE, S_EMITH,
        S_NR, S_SSTART, S_SWAIT, S_SDEC, S_FIN,
        S_D0, S_D1, S_DW1, S_DN, S_DM, S_D2, S_DW2, S_DST
    } t_state;

    t_state r_state, n_state;
    logic   r_fornew, n_fornew;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_fornew = r_fornew;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_IDLE;
                unique case (i_stat.op)
                    OP_REQ, OP_TICK: n_state = S_DR;
                    OP_DONE:         o_cmd.do_done = i_stat.done_ok;
                    OP_HRST: begin
                        if (i_stat.rst_ok) begin
                            o_cmd.cmp_init = 1'b1;
                            n_state        = S_CRD;
                        end
                    end
                    OP_UP:           o_cmd.do_up = 1'b1;
                    OP_DOWN:         o_cmd.do_dn = 1'b1;
                    OP_SAMPLE:       n_state = S_D0;
                    default:         n_state = S_IDLE;
                endcase
            end
            S_CRD: begin
                if (i_stat.cmp_end) begin
                    o_cmd.cmp_fin = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_state = S_CUSE;
                end
            end
            S_CUSE: begin
                o_cmd.cmp_step = 1'b1;
                n_state        = S_CRD;
            end
            // head entry read lands during this cycle
            S_DR: begin
                if (!i_stat.wc_zero) begin
                    n_state = S_DDEC;
                end else if (i_stat.op == OP_REQ) begin
                    n_state = S_NR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DDEC: begin
                o_cmd.src_new = 1'b0;
                priority if (i_stat.rc_zero || i_stat.exp_q) begin
                    o_cmd.dec = i_stat.rc_zero ? DEC_OFFLINE : DEC_EXPIRED;
                    if (i_stat.can_emit) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.adv  = 1'b1;
                        n_state    = S_DR;
                    end
                end else if (!i_stat.fc_zero) begin
                    n_fornew = 1'b0;
                    n_state  = S_POP;
                end else if (!i_stat.fb_zero) begin
                    o_cmd.dec = DEC_FALLBACK;
                    if (i_stat.can_emit) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.adv    = 1'b1;
                        o_cmd.fb_dec = 1'b1;
                        n_state      = S_DR;
                    end
                end else if (i_stat.op == OP_REQ) begin
                    n_state = S_NR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POP: begin
                o_cmd.stk_pop = 1'b1;
                n_state       = S_TAKE;
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_state    = S_EMITH;
            end
            S_EMITH: begin
                o_cmd.dec     = DEC_HELPER;
                o_cmd.use_h   = 1'b1;
                o_cmd.src_new = r_fornew;
                if (i_stat.can_emit) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.adv  = !r_fornew;
                    n_state    = r_fornew ? S_FIN : S_DR;
                end
            end
            S_NR: begin
                o_cmd.src_new = 1'b1;
                priority if (i_stat.rc_zero || i_stat.exp_new || !i_stat.fc_zero == 1'b0 &&
                             !i_stat.fb_zero) begin
                    if (i_stat.rc_zero) begin
                        o_cmd.dec = DEC_OFFLINE;
                    end else if (i_stat.exp_new) begin
                        o_cmd.dec = DEC_EXPIRED;
                    end else begin
                        o_cmd.dec = DEC_FALLBACK;
                    end
                    if (i_stat.can_emit) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_FIN;
                    end
                end else if (!i_stat.fc_zero) begin
                    n_fornew = 1'b1;
                    n_state  = S_POP;
                end else if (i_stat.slow_need) begin
                    n_state = S_SSTART;
                end else begin
                    n_state = S_SDEC;
                end
            end
            S_SSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_WAIT;
                n_state         = S_SWAIT;
            end
            S_SWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_SDEC;
                end
            end
            S_SDEC: begin
                o_cmd.src_new = 1'b1;
                priority if (i_stat.slow_need && i_stat.slow) begin
                    o_cmd.dec = DEC_SLOW;
                end else if (i_stat.room) begin
                    o_cmd.dec = DEC_QUEUED;
                    o_cmd.enq = i_stat.can_emit;
                end else begin
                    o_cmd.dec = DEC_FULL;
                end
                if (i_stat.can_emit) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_FIN;
                end
            end
            // release the held result as the final one of this event
            S_FIN: begin
                o_cmd.flush = i_stat.can_flush;
                if (i_stat.can_flush) begin
                    n_state = S_IDLE;
                end
            end
            S_D0: begin
                o_cmd.avg_init = 1'b1;
                n_state        = S_D1;
            end
            S_D1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_N;
                n_state         = S_DW1;
            end
            S_DW1: begin
                if (!i_stat.div_busy) begin
                    n_state = S_DN;
                end
            end
            S_DN: begin
                o_cmd.n_latch = 1'b1;
                n_state       = S_DM;
            end
            S_DM: begin
                o_cmd.prod_latch = 1'b1;
                n_state          = S_D2;
            end
            S_D2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_AVG;
                n_state         = S_DW2;
            end
            S_DW2: begin
                if (!i_stat.div_busy) begin
                    n_state = S_DST;
                end
            end
            S_DST: begin
                o_cmd.avg_store = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fornew <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fornew <= n_fornew;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/request_admission_dispatcher_core.sv =====
// Top level of the request admission dispatcher: controller plus datapath.
// A request holds the input until its event ends: queued entries drain first (a tick only
// drains), then the new one takes a helper, a fallback, a queue slot or is refused, with a
// division for the wait estimate when needed; output stalls can hold any result.
// Delay samples run two 52-step divisions; a helper reset scans every free entry.
// Throughput: one request in flight at a time. Reset: synchronous, active low, config 16/16.
`default_nettype none
module request_admission_dispatcher_core #(
    parameter int HELPERS     = rad_pkg::HELPERS_DEF,
    parameter int QUEUE_DEPTH = rad_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request in
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // task_id[15:0], deadline_ms[63:16], now_ms[111:64], helper_index[115:112],
    // sample_us[139:116], fallback_free[144:140], zero pad up to 151
    input  wire logic [rad_pkg::IN_DATA_W-1:0] i_s_tdata,
    // operation[2:0]
    input  wire logic [2:0]                    i_s_tuser,
    // decisions out
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // out_task_id[15:0], assigned_helper[19:16], zero pad up to 23
    output logic [rad_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // decision[2:0]
    output logic [2:0]                         o_m_tuser,
    output logic                               o_m_tlast,
    // configuration writes: index 0 helper_max, index 1 queue_limit
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [0:0]                    i_cfg_addr,
    input  wire logic [rad_pkg::CFG_W-1:0]     i_cfg_data
);
    import rad_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // registers accept a write every cycle
    assign o_cfg_ready = 1'b1;

    // sequence each request through drain, decision and result release
    rad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // hold state, stack, queue, divider and the staged result pair
    rad_dp #(
        .HELPERS     (HELPERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );
endmodule
`default_nettype wire
